// ===== hw/rtl/idi_pkg.sv =====
// ----------------------------------------------------------------------------
// idi_pkg: shared types and constants of the inverse distance interpolator
// Holds word codes, register indexes, fixed widths, the sequencer states, the
// fractional power table and the request/response structs of the divider.
// ----------------------------------------------------------------------------
package idi_pkg;

  // word kinds on the request channel
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // configuration register indexes
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned REG_DATA_W = 32;
  localparam logic [REG_IDX_W-1:0] REG_MIN_X      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_X      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_DIV = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ANCHOR_EXP = 2'd3;

  // configuration reset values
  localparam logic signed [31:0] MIN_X_RESET      = 32'sd0;
  localparam logic signed [31:0] MAX_X_RESET      = 32'sd1445068800;
  localparam logic [30:0]        WEIGHT_DIV_RESET = 31'd65536;
  localparam logic [15:0]        ANCHOR_EXP_RESET = 16'd8192;

  // datapath widths
  localparam int unsigned YT_W   = 40;   // running sum of stored y
  localparam int unsigned PV_W   = 26;   // log-domain term, Q.16 signed
  localparam int unsigned MAN_W  = 31;   // Q1.30 mantissa / Q.30 power
  localparam int unsigned R_W    = 21;   // scaled weight, Q.20, at most 1.0
  localparam int unsigned RA_W   = 22;   // sum of the two anchor weights
  localparam int unsigned MUL_W  = 33;   // signed multiplier operand
  localparam int unsigned PROD_W = 66;   // multiplier product
  localparam int unsigned DIV_W  = 64;   // divider operand width
  localparam int unsigned ACC_W  = 64;   // numerator and denominator sums

  // log2(0.0001) in Q.16: terms at or below this count as a hit
  localparam logic signed [PV_W-1:0] HIT_LIMIT = -26'sd870824;
  // integer shift at which a scaled weight is zero
  localparam int unsigned WEIGHT_SHIFT_LIMIT = 44;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_L_FETCH,
    ST_L_DIFF,
    ST_L_NORM,
    ST_L_SQ,
    ST_L_MUL_E,
    ST_L_TERM,
    ST_W_FETCH,
    ST_W_INIT,
    ST_W_POW,
    ST_W_ACC,
    ST_W_NEXT,
    ST_A_MUL,
    ST_D1_START,
    ST_D1_WAIT,
    ST_D2_START,
    ST_D2_WAIT,
    ST_FINISH
  } state_t;

  // which term of a query is under work
  typedef enum logic [1:0] {
    TERM_LO,
    TERM_PT,
    TERM_HI
  } term_t;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Q.30 table of 2^(-2^-(j+1)), built by repeated integer square roots
  typedef logic [15:0][MAN_W-1:0] pow_tab_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'd1 << 62;
    rem  = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic pow_tab_t build_pow_tab();
    pow_tab_t    tab;
    logic [63:0] v;
    v = 64'd1 << 29;
    for (int j = 0; j < 16; j++) begin
      v      = isqrt64(v << 30);
      tab[j] = v[MAN_W-1:0];
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

// ===== hw/rtl/idi_if.sv =====
// ----------------------------------------------------------------------------
// idi_if: request and response channels of the interpolator
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface idi_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] coord;
  logic signed [31:0] value;
  logic [15:0]        exponent;

  modport source (output valid, kind, coord, value, exponent, input ready);
  modport sink (input valid, kind, coord, value, exponent, output ready);
endinterface

interface idi_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               zero_denominator;

  modport source (output valid, result, zero_denominator, input ready);
  modport sink (input valid, result, zero_denominator, output ready);
endinterface

// ===== hw/rtl/inverse_distance_interpolator.sv =====
// ----------------------------------------------------------------------------
// inverse_distance_interpolator: 1-D Shepard interpolator, Q16.16
// Sequencer around one shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   req carries words of three kinds: load appends (coord, value, exponent)
//   to the point store (dropped once MAX_POINTS are held), clear empties the
//   store, query interpolates at coord. Only a query returns a word on rsp.
//   The wr_* port sets min_x, max_x, weight_divisor and anchor_exponent; write
//   it only while no query is under way.
// Sequence:
//   Load and clear are taken from idle and leave the block idle. A query
//   walks every term (the two anchors plus every stored point) twice, once
//   for the log terms and once for the weights. Most of its work lies in the
//   multiplier loop: 16 squarings for each log term, up to 16 products for
//   each weight, plus up to two divisions at the end. A query that hits a
//   point returns early. req is not ready while a query is in work.
// Reset: synchronous; the store empties, registers return to their defaults.
// Stall: the result waits in an output register; the next load or clear is
//   taken meanwhile, and a following query holds at its end until rsp drains.
// ----------------------------------------------------------------------------
module inverse_distance_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  idi_req_if.sink                              req,
  idi_rsp_if.source                            rsp,
  input  logic                                 wr_en,
  input  logic [idi_pkg::REG_IDX_W-1:0]        wr_index,
  input  logic [idi_pkg::REG_DATA_W-1:0]       wr_data
);
  import idi_pkg::*;

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  // configuration
  logic signed [31:0] min_x;
  logic signed [31:0] max_x;
  logic [30:0]        weight_div;
  logic [15:0]        anchor_exp;

  // point store and per-point log terms
  logic signed [31:0]     mem_x [MAX_POINTS];
  logic signed [31:0]     mem_y [MAX_POINTS];
  logic [15:0]            mem_e [MAX_POINTS];
  logic signed [PV_W-1:0] mem_pv [MAX_POINTS];
  logic signed [31:0]     rd_x;
  logic signed [31:0]     rd_y;
  logic [15:0]            rd_e;
  logic signed [PV_W-1:0] rd_pv;
  logic [CNT_W-1:0]       point_count;
  logic signed [YT_W-1:0] y_total;

  // sequencer
  state_t state;
  state_t state_next;

  // query datapath
  logic signed [31:0]      qx;
  term_t                   tsel;
  logic [IDX_W-1:0]        pidx;
  logic [15:0]             cur_e;
  logic [31:0]             norm;
  logic [4:0]              pexp;
  logic [MAN_W-1:0]        man;
  logic [15:0]             frac;
  logic [4:0]              step;
  logic [1:0]              ph;
  logic signed [PV_W-1:0]  pv_cur;
  logic                    hit_cur;
  logic signed [PV_W-1:0]  p_lo;
  logic signed [PV_W-1:0]  p_hi;
  logic signed [PV_W-1:0]  m;
  logic [15:0]             s_f;
  logic [5:0]              ksh;
  logic [MAN_W-1:0]        v;
  logic [R_W-1:0]          r_cur;
  logic [RA_W-1:0]         ra;
  logic [ACC_W-1:0]        rsum;
  logic signed [ACC_W-1:0] num;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] den;
  logic signed [31:0]      res_val;
  logic                    res_zero;

  // output register
  logic               out_valid;
  logic signed [31:0] out_result;
  logic               out_zero;
  logic               out_free;

  // shared units
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // combinational helpers
  logic                    accept;
  logic                    store_room;
  logic signed [YT_W:0]    y_sum;
  logic                    pt_last;
  logic signed [31:0]      xi_sel;
  logic [15:0]             e_sel;
  logic signed [32:0]      diff;
  logic [31:0]             d;
  logic signed [20:0]      lg;
  logic signed [PROD_W-1:0] pv_round;
  logic signed [PV_W-1:0]  pv_new;
  logic [31:0]             sq_t;
  logic signed [PV_W-1:0]  pv_sel;
  logic signed [PV_W:0]    s_diff;
  logic [PV_W-16:0]        k;
  logic                    pow_bit;
  logic [MAN_W-1:0]        v_sh;
  logic [31:0]             div2;
  logic [ACC_W-1:0]        q_mag;

  idi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  idi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign store_room = (point_count < CNT_W'(MAX_POINTS));
  assign y_sum      = {y_total[YT_W-1], y_total} + (YT_W+1)'(req.value);
  assign pt_last    = ((CNT_W'(pidx) + CNT_W'(1)) == point_count);
  assign out_free   = !out_valid || rsp.ready;

  // term operands
  always_comb begin
    unique case (tsel)
      TERM_LO: begin
        xi_sel = min_x;
        e_sel  = anchor_exp;
        pv_sel = p_lo;
      end
      TERM_HI: begin
        xi_sel = max_x;
        e_sel  = anchor_exp;
        pv_sel = p_hi;
      end
      default: begin
        xi_sel = rd_x;
        e_sel  = rd_e;
        pv_sel = rd_pv;
      end
    endcase
  end

  // distance, log and weight arithmetic
  assign diff     = {qx[31], qx} - {xi_sel[31], xi_sel};
  assign d        = diff[32] ? 32'(-diff) : diff[31:0];
  assign lg       = {pexp - 5'd16, frac};
  assign pv_round = mul_p + PROD_W'(2048);
  assign pv_new   = pv_round[PV_W+11:12];
  assign sq_t     = mul_p[61:30];
  assign s_diff   = {pv_sel[PV_W-1], pv_sel} - {m[PV_W-1], m};
  assign k        = s_diff[PV_W:16];
  assign pow_bit  = s_f[4'd15 - step[3:0]];
  assign v_sh     = v >> (6'd10 + ksh);
  assign div2     = {((weight_div == '0) ? 31'd1 : weight_div), 1'b0};
  assign q_mag    = div_rsp.quotient;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, multiplier operands and divider requests
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid && req.kind == KIND_QUERY) state_next = ST_L_FETCH;
      end
      ST_L_FETCH: state_next = ST_L_DIFF;
      ST_L_DIFF: state_next = (d == '0) ? ST_L_TERM : ST_L_NORM;
      ST_L_NORM: begin
        if (norm[31]) state_next = ST_L_SQ;
      end
      ST_L_SQ: begin
        mul_a = {2'b00, man};
        mul_b = {2'b00, man};
        if (ph[0] && step == 5'd15) state_next = ST_L_MUL_E;
      end
      ST_L_MUL_E: begin
        mul_a = {17'd0, cur_e};
        mul_b = MUL_W'(lg);
        if (ph[0]) state_next = ST_L_TERM;
      end
      ST_L_TERM: begin
        if (hit_cur) state_next = ST_FINISH;
        else if (tsel == TERM_HI) state_next = ST_W_FETCH;
        else state_next = ST_L_FETCH;
      end
      ST_W_FETCH: state_next = ST_W_INIT;
      ST_W_INIT: state_next = ST_W_POW;
      ST_W_POW: begin
        mul_a = {2'b00, v};
        mul_b = {2'b00, POW_TAB[step[3:0]]};
        if (step[4]) state_next = ST_W_ACC;
      end
      ST_W_ACC: begin
        mul_a = MUL_W'(rd_y);
        mul_b = {12'd0, r_cur};
        if (ph[0] || tsel != TERM_PT) state_next = ST_W_NEXT;
      end
      ST_W_NEXT: state_next = (tsel == TERM_HI) ? ST_A_MUL : ST_W_FETCH;
      ST_A_MUL: begin
        if (!ph[1]) mul_a = MUL_W'($signed(y_total[YT_W-1:20]));
        else mul_a = {13'd0, y_total[19:0]};
        mul_b = {11'd0, ra};
        if (ph == 2'd3) state_next = ST_D1_START;
      end
      ST_D1_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc[ACC_W-1] ? DIV_W'(-acc) : DIV_W'(acc);
        div_req.divisor  = DIV_W'(div2);
        state_next       = ST_D1_WAIT;
      end
      ST_D1_WAIT: begin
        if (div_rsp.done) state_next = ST_D2_START;
      end
      ST_D2_START: begin
        if (den == '0) begin
          state_next = ST_FINISH;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = num[ACC_W-1] ? DIV_W'(-num) : DIV_W'(num);
          div_req.divisor  = den[ACC_W-1] ? DIV_W'(-den) : DIV_W'(den);
          state_next       = ST_D2_WAIT;
        end
      end
      ST_D2_WAIT: begin
        if (div_rsp.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x      <= MIN_X_RESET;
      max_x      <= MAX_X_RESET;
      weight_div <= WEIGHT_DIV_RESET;
      anchor_exp <= ANCHOR_EXP_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MIN_X:      min_x      <= wr_data;
        REG_MAX_X:      max_x      <= wr_data;
        REG_WEIGHT_DIV: weight_div <= wr_data[30:0];
        REG_ANCHOR_EXP: anchor_exp <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // store fill level and running y sum
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      y_total     <= '0;
    end else if (accept && req.kind == KIND_CLEAR) begin
      point_count <= '0;
      y_total     <= '0;
    end else if (accept && req.kind == KIND_LOAD && store_room) begin
      point_count <= point_count + 1'b1;
      if (y_sum[YT_W] != y_sum[YT_W-1]) begin
        y_total <= {y_sum[YT_W], {(YT_W-1){~y_sum[YT_W]}}};
      end else begin
        y_total <= y_sum[YT_W-1:0];
      end
    end
  end

  // memories: write on load and on each stored point's log term, read at the term index
  always_ff @(posedge clk) begin
    if (accept && req.kind == KIND_LOAD && store_room) begin
      mem_x[point_count[IDX_W-1:0]] <= req.coord;
      mem_y[point_count[IDX_W-1:0]] <= req.value;
      mem_e[point_count[IDX_W-1:0]] <= req.exponent;
    end
    if (state == ST_L_TERM && !hit_cur && tsel == TERM_PT) begin
      mem_pv[pidx] <= pv_cur;
    end
    rd_x  <= mem_x[pidx];
    rd_y  <= mem_y[pidx];
    rd_e  <= mem_e[pidx];
    rd_pv <= mem_pv[pidx];
  end

  // term walk
  always_ff @(posedge clk) begin
    if (rst) begin
      tsel <= TERM_LO;
      pidx <= '0;
    end else if (accept) begin
      tsel <= TERM_LO;
      pidx <= '0;
    end else if ((state == ST_L_TERM && !hit_cur) || state == ST_W_NEXT) begin
      unique case (tsel)
        TERM_LO: begin
          if (point_count != '0) begin
            tsel <= TERM_PT;
            pidx <= '0;
          end else begin
            tsel <= TERM_HI;
          end
        end
        TERM_PT: begin
          if (pt_last) tsel <= TERM_HI;
          else pidx <= pidx + 1'b1;
        end
        default: begin
          tsel <= TERM_LO;
          pidx <= '0;
        end
      endcase
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qx <= req.coord;
      end
      ST_L_DIFF: begin
        cur_e   <= e_sel;
        norm    <= d;
        pexp    <= 5'd31;
        step    <= '0;
        ph      <= '0;
        pv_cur  <= '0;
        hit_cur <= (e_sel != '0);
      end
      ST_L_NORM: begin
        // normalize: eight places while the top byte is clear, then one
        if (norm[31]) begin
          man  <= norm[31:1];
          frac <= '0;
        end else if (norm[31:24] == '0) begin
          norm <= norm << 8;
          pexp <= pexp - 5'd8;
        end else begin
          norm <= norm << 1;
          pexp <= pexp - 5'd1;
        end
      end
      ST_L_SQ: begin
        // square the mantissa; an overflow past 2.0 gives a fraction bit
        if (ph[0]) begin
          frac <= {frac[14:0], sq_t[31]};
          man  <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
          step <= step + 1'b1;
          ph   <= '0;
        end else begin
          ph <= 2'd1;
        end
      end
      ST_L_MUL_E: begin
        if (ph[0]) begin
          pv_cur  <= pv_new;
          hit_cur <= (pv_new <= HIT_LIMIT);
          ph      <= '0;
        end else begin
          ph <= 2'd1;
        end
      end
      ST_L_TERM: begin
        if (hit_cur) begin
          res_val  <= (tsel == TERM_PT) ? rd_y : '0;
          res_zero <= 1'b0;
        end else begin
          if (tsel == TERM_LO) begin
            p_lo <= pv_cur;
            m    <= pv_cur;
          end else begin
            if (tsel == TERM_HI) p_hi <= pv_cur;
            if (pv_cur < m) m <= pv_cur;
          end
          num  <= '0;
          rsum <= '0;
          ra   <= '0;
        end
      end
      ST_W_INIT: begin
        s_f  <= s_diff[15:0];
        ksh  <= k[5:0];
        v    <= (k >= WEIGHT_SHIFT_LIMIT) ? '0 : MAN_W'(1) << 30;
        step <= '0;
        ph   <= '0;
      end
      ST_W_POW: begin
        // multiply in one table entry for each set fraction bit
        if (step[4]) begin
          r_cur <= v_sh[R_W-1:0];
        end else if (!pow_bit) begin
          step <= step + 1'b1;
        end else if (ph[0]) begin
          v    <= mul_p[60:30];
          step <= step + 1'b1;
          ph   <= '0;
        end else begin
          ph <= 2'd1;
        end
      end
      ST_W_ACC: begin
        if (tsel != TERM_PT) begin
          ra <= ra + RA_W'(r_cur);
        end else if (ph[0]) begin
          num  <= num + mul_p[ACC_W-1:0];
          rsum <= rsum + ACC_W'(r_cur);
          ph   <= '0;
        end else begin
          ph <= 2'd1;
        end
      end
      ST_W_NEXT: begin
        ph <= '0;
      end
      ST_A_MUL: begin
        // y_total * ra as high and low partial products
        ph <= ph + 1'b1;
        if (ph == 2'd1) acc <= {mul_p[43:0], 20'd0};
        if (ph == 2'd3) acc <= acc + mul_p[ACC_W-1:0];
      end
      ST_D1_WAIT: begin
        if (div_rsp.done) begin
          den <= $signed(rsum) + (acc[ACC_W-1] ? -$signed(q_mag) : $signed(q_mag));
        end
      end
      ST_D2_START: begin
        if (den == '0) begin
          res_val  <= '0;
          res_zero <= 1'b1;
        end
      end
      ST_D2_WAIT: begin
        // saturate the signed quotient to 32 bits
        if (div_rsp.done) begin
          res_zero <= 1'b0;
          if (num[ACC_W-1] != den[ACC_W-1]) begin
            res_val <= (q_mag > ACC_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q_mag);
          end else begin
            res_val <= (q_mag > ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_mag[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  // output register: load at the end of a query, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_result <= res_val;
      out_zero   <= res_zero;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.result           = out_result;
  assign rsp.zero_denominator = out_zero;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy && div_req.divisor != '0)
    else $error("divider started while busy or with a zero divisor");

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept && req.kind == KIND_QUERY |=> state == ST_L_FETCH)
    else $error("query word did not start the term walk");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result word raised outside the finish step");

endmodule

// ===== hw/rtl/idi_mul.sv =====
// ----------------------------------------------------------------------------
// idi_mul: shared signed multiplier
// One 33 x 33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module idi_mul (
  input  logic                                clk,
  input  logic signed [idi_pkg::MUL_W-1:0]    a,
  input  logic signed [idi_pkg::MUL_W-1:0]    b,
  output logic signed [idi_pkg::PROD_W-1:0]   p
);
  import idi_pkg::*;

  // register the product
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ===== hw/rtl/idi_div.sv =====
// ----------------------------------------------------------------------------
// idi_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module idi_div (
  input  logic               clk,
  input  logic               rst,
  input  idi_pkg::div_req_t  req,
  output idi_pkg::div_rsp_t  rsp
);
  import idi_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;

  // shift in the next dividend bit and try the subtraction
  assign shifted = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial;
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the inverse distance interpolator
// Drives load, query and clear words through a directed table and then random
// point sets, predicts each untyped query result with a bit-true Q16.16 Shepard
// model kept in this file, and checks the responses in order under several
// register settings and idle/stall mixes, including one long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
  import idi_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STORE_DEPTH = 64;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] coord;
    logic signed [31:0] value;
    logic [15:0]        exponent;
    bit                 typed;
    logic signed [31:0] t_result;
    bit                 t_zero;
  } word_t;

  typedef struct {
    logic signed [31:0] result;
    bit                 zero;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic wr_en = 0;
  logic [REG_IDX_W-1:0]  wr_index = '0;
  logic [REG_DATA_W-1:0] wr_data = '0;

  idi_req_if req ();
  idi_rsp_if rsp ();

  inverse_distance_interpolator dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // shadow of the block's state and registers
  int                 pt_x [STORE_DEPTH];
  int                 pt_y [STORE_DEPTH];
  int unsigned        pt_e [STORE_DEPTH];
  int                 pt_count;
  longint             y_sum;
  int                 cfg_min, cfg_max;
  int unsigned        cfg_div, cfg_aexp;
  longint unsigned    frac_pow [16];

  word_t   word_q [$];
  answer_t answer_q [$];
  word_t   cur;
  int      src_idle, snk_idle, hold_left;
  int      errors, results_seen, words_sent, settings_run;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= v && b < 64'd1 << 32) r = b;
    end
    return r;
  endfunction

  // log2 of |x - xi| scaled by exponent, Q.16; flag terms at or below the hit limit
  function automatic longint dist_log(longint x, longint xi, int unsigned e,
                                      output bit hit);
    longint diff, frac, lg, pv;
    longint unsigned d, man;
    int p;
    hit = 0;
    diff = x - xi;
    d = diff < 0 ? -diff : diff;
    if (d == 0) begin
      hit = (e != 0);
      return 0;
    end
    p = 31;
    while (d[p] == 1'b0) p--;
    man = (p <= 30) ? (d << (30 - p)) : (d >> (p - 30));
    frac = 0;
    for (int j = 0; j < 16; j++) begin
      man = (man * man) >> 30;
      frac = frac << 1;
      if (man >= (64'd1 << 31)) begin
        frac = frac | 1;
        man = man >> 1;
      end
    end
    lg = longint'(p - 16) * 65536 + frac;
    pv = (longint'(e) * lg + 2048) >>> 12;
    hit = (pv <= longint'(HIT_LIMIT));
    return pv;
  endfunction

  // 2^-s in Q.20 for a Q.16 shift s >= 0
  function automatic longint weight_q20(longint s);
    longint unsigned k, f, v;
    k = s >> 16;
    f = s & 'hFFFF;
    if (k >= WEIGHT_SHIFT_LIMIT) return 0;
    v = 64'd1 << 30;
    for (int j = 0; j < 16; j++)
      if (f[15 - j]) v = (v * frac_pow[j]) >> 30;
    return longint'(v >> (10 + k));
  endfunction

  function automatic answer_t interpolate(longint x);
    answer_t a;
    longint  pv [STORE_DEPTH];
    bit      ph [STORE_DEPTH];
    longint  p_lo, p_hi, m, num, den, rsum, ra, dv;
    longint unsigned an, ad, q;
    bit      h_lo, h_hi;
    a.result = 0;
    a.zero = 0;
    p_lo = dist_log(x, cfg_min, cfg_aexp, h_lo);
    p_hi = dist_log(x, cfg_max, cfg_aexp, h_hi);
    for (int i = 0; i < pt_count; i++) pv[i] = dist_log(x, pt_x[i], pt_e[i], ph[i]);
    // first hit in scan order decides
    if (h_lo) return a;
    for (int i = 0; i < pt_count; i++)
      if (ph[i]) begin
        a.result = pt_y[i];
        return a;
      end
    if (h_hi) return a;
    m = p_lo < p_hi ? p_lo : p_hi;
    for (int i = 0; i < pt_count; i++) if (pv[i] < m) m = pv[i];
    num = 0;
    rsum = 0;
    for (int i = 0; i < pt_count; i++) begin
      rsum += weight_q20(pv[i] - m);
      num += longint'(pt_y[i]) * weight_q20(pv[i] - m);
    end
    ra = weight_q20(p_lo - m) + weight_q20(p_hi - m);
    dv = cfg_div == 0 ? 1 : cfg_div;
    den = rsum + (y_sum * ra) / (2 * dv);
    if (den == 0) begin
      a.zero = 1;
      return a;
    end
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = an / ad;
    if ((num < 0) != (den < 0)) a.result = q > 64'h8000_0000 ? 32'h8000_0000 : -q;
    else a.result = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q;
    return a;
  endfunction

  // advance the shadow state for one accepted word
  task automatic absorb_word(word_t w);
    answer_t a;
    case (w.kind)
      KIND_LOAD: begin
        if (pt_count < STORE_DEPTH) begin
          pt_x[pt_count] = w.coord;
          pt_y[pt_count] = w.value;
          pt_e[pt_count] = w.exponent;
          pt_count++;
          y_sum += longint'(w.value);
          if (y_sum > 64'sd549755813887) y_sum = 64'sd549755813887;
          if (y_sum < -64'sd549755813888) y_sum = -64'sd549755813888;
        end
      end
      KIND_QUERY: begin
        a = interpolate(w.coord);
        if (w.typed) begin
          a.result = w.t_result;
          a.zero = w.t_zero;
        end
        answer_q.push_back(a);
      end
      KIND_CLEAR: begin
        pt_count = 0;
        y_sum = 0;
      end
      default: ;
    endcase
  endtask

  // request side: offer words, drop valid on idle rolls
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        absorb_word(cur);
        words_sent++;
      end
      if (!req.valid || req.ready) begin
        if (word_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          cur = word_q.pop_front();
          req.valid <= 1'b1;
          req.kind <= cur.kind;
          req.coord <= cur.coord;
          req.value <= cur.value;
          req.exponent <= cur.exponent;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // response side: stall at random, or hold off for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %0d", rsp.result);
      end else begin
        answer_t a;
        a = answer_q.pop_front();
        if (rsp.result !== a.result || rsp.zero_denominator !== a.zero) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected result %0d zero_den %0b, got %0d %0b",
                     a.result, a.zero, rsp.result, rsp.zero_denominator);
        end
      end
    end
  end

  function automatic word_t mk(logic [1:0] k, logic signed [31:0] c,
                               logic signed [31:0] v, logic [15:0] e);
    word_t w;
    w.kind = k;
    w.coord = c;
    w.value = v;
    w.exponent = e;
    w.typed = 0;
    w.t_result = 0;
    w.t_zero = 0;
    return w;
  endfunction

  function automatic word_t mk_typed(logic signed [31:0] c, logic signed [31:0] r, bit z);
    word_t w;
    w = mk(KIND_QUERY, c, 0, 0);
    w.typed = 1;
    w.t_result = r;
    w.t_zero = z;
    return w;
  endfunction

  function automatic logic [15:0] pick_exp();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd4096;
      2: return 16'd8192;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // random point sets followed by queries near and away from the points
  task automatic queue_random(int count);
    int made, npts, nq;
    int xs [$];
    word_t w;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 5) begin
        word_q.push_back(mk(KIND_UNUSED, $urandom, $urandom, 16'($urandom)));
        continue;
      end
      if ($urandom_range(3) != 0) begin
        word_q.push_back(mk(KIND_CLEAR, $urandom, $urandom, 16'($urandom)));
        made++;
      end
      npts = ($urandom_range(99) < 3) ? $urandom_range(60, 70) : $urandom_range(0, 8);
      xs.delete();
      for (int i = 0; i < npts; i++) begin
        w = mk(KIND_LOAD, $urandom, $urandom, pick_exp());
        if ($urandom_range(1)) w.coord = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        if ($urandom_range(1)) w.value = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        xs.push_back(w.coord);
        word_q.push_back(w);
        made++;
      end
      nq = $urandom_range(1, 5);
      for (int i = 0; i < nq; i++) begin
        w = mk(KIND_QUERY, $urandom, $urandom, 16'($urandom));
        if (xs.size() > 0 && $urandom_range(2) != 0) begin
          w.coord = xs[$urandom_range(xs.size() - 1)];
          if ($urandom_range(3) != 0)
            w.coord = w.coord + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        end
        word_q.push_back(w);
        made++;
      end
    end
  endtask

  // write all four registers back to back while the block is idle
  task automatic set_regs(int mn, int mx, int unsigned dv, int unsigned ae);
    logic [REG_DATA_W-1:0] vals [4];
    logic [REG_IDX_W-1:0]  idx [4];
    vals = '{mn, mx, dv, ae};
    idx = '{REG_MIN_X, REG_MAX_X, REG_WEIGHT_DIV, REG_ANCHOR_EXP};
    for (int i = 0; i < 4; i++) begin
      wr_en <= 1'b1;
      wr_index <= idx[i];
      wr_data <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    cfg_min = mn;
    cfg_max = mx;
    cfg_div = dv & 32'h7FFF_FFFF;
    cfg_aexp = ae & 16'hFFFF;
    settings_run++;
  endtask

  task automatic drain();
    while (word_q.size() > 0 || req.valid || answer_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  word_t directed [$];

  initial begin
    longint unsigned v;
    req.valid = 0;
    req.kind = KIND_CLEAR;
    req.coord = 0;
    req.value = 0;
    req.exponent = 0;
    rsp.ready = 0;
    src_idle = 0;
    snk_idle = 0;
    hold_left = 0;
    errors = 0;
    results_seen = 0;
    words_sent = 0;
    settings_run = 1;
    pt_count = 0;
    y_sum = 0;
    cfg_min = MIN_X_RESET;
    cfg_max = MAX_X_RESET;
    cfg_div = WEIGHT_DIV_RESET;
    cfg_aexp = ANCHOR_EXP_RESET;
    v = 64'd1 << 29;
    for (int j = 0; j < 16; j++) begin
      v = root64(v << 30);
      frac_pow[j] = v;
    end

    // directed table: typed rows are plain to read, the rest are predicted
    directed = '{
      mk_typed(0, 0, 0),                                   // on lower anchor
      mk_typed(32'sh0001_0000, 0, 1),                      // empty store, no weight
      mk(KIND_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF),
      mk(KIND_LOAD, 32'sh8000_0000, 32'sh8000_0000, 16'h0000),
      mk(KIND_LOAD, 32'sh0005_0000, 32'sd123, 16'h1000),
      mk_typed(32'sh0005_0000, 32'sd123, 0),               // exact point hit
      mk(KIND_QUERY, 32'sh8000_0000, 0, 0),                // zero distance, exponent 0
      mk(KIND_QUERY, 32'sh7FFF_FFFF, 0, 0),
      mk(KIND_QUERY, 32'sh0002_8000, 0, 0),
      mk(KIND_QUERY, 32'sh5619_0000, 0, 0),                // 9.0 below upper anchor
      mk(KIND_UNUSED, 32'sh1234_5678, 32'sh1111, 16'h2222),
      mk(KIND_QUERY, 32'sh0005_0100, 0, 0),                // close, not exact
      mk(KIND_CLEAR, 0, 0, 0),
      mk(KIND_LOAD, 32'sh0000_0100, 32'sh0010_0000, 16'hFFFF),
      mk(KIND_LOAD, 32'sh0003_0000, -32'sh0020_0000, 16'h0800),
      mk(KIND_QUERY, 0, 0, 0),
      mk(KIND_QUERY, 32'sh0000_0101, 0, 0),                // below hit threshold
      mk(KIND_QUERY, 32'sh0001_8000, 0, 0),
      mk(KIND_QUERY, -32'sh0100_0000, 0, 0),
      mk(KIND_CLEAR, 0, 0, 0),
      mk_typed(32'sh0001_0000, 0, 1)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) word_q.push_back(directed[i]);
    drain();

    // phases: register settings crossed with idle and stall mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: set_regs(32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
        2: set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        3: set_regs(-32'sh0080_0000, 32'sh0080_0000, 0, 16'h1000);
        4: set_regs(0, 0, 32'h0000_0100, 16'h3000);
        5, 6, 7: set_regs($urandom, $urandom, $urandom_range(1, 32'h7FFF_FFFF), $urandom);
        default: ;
      endcase
      case (ph % 4)
        0: begin src_idle = 0;  snk_idle = 0;  end
        1: begin src_idle = 54; snk_idle = 0;  end
        2: begin src_idle = 0;  snk_idle = 54; end
        default: begin src_idle = 26; snk_idle = 26; end
      endcase
      if (ph == 2) hold_left = 6000;
      queue_random(185);
      drain();
    end

    $display("%0d words sent, %0d results checked across %0d register settings",
             words_sent, results_seen, settings_run);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d errors", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d words queued, %0d results pending",
             word_q.size(), answer_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
